@@ design/scatr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_pkg
// Shared types, codes and helpers for the answer-to-reset parser.
// ----------------------------------------------------------------------------
package scatr_pkg;

  localparam logic [7:0] TS_DIRECT_BYTE  = 8'h3B;
  localparam logic [7:0] TS_INVERSE_BYTE = 8'h03;
  localparam logic [7:0] TS_INVERSE_SHOW = 8'h3F;

  // byte classes
  localparam logic [2:0] CLS_TS      = 3'd0;
  localparam logic [2:0] CLS_T0      = 3'd1;
  localparam logic [2:0] CLS_IFACE   = 3'd2;
  localparam logic [2:0] CLS_HIST    = 3'd3;
  localparam logic [2:0] CLS_TCK     = 3'd4;
  localparam logic [2:0] CLS_IGNORED = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BAD_TS = 2'd1;
  localparam logic [1:0] ERR_OVFL   = 2'd2;

  typedef enum logic [1:0] {
    TS_KIND_DIRECT,
    TS_KIND_INVERSE,
    TS_KIND_BAD
  } ts_kind_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic [5:0] byte_index;
    logic [2:0] byte_class;
    logic [3:0] protocol;
    logic       inverse;
    logic       done_res;
    logic [1:0] error;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] inv_byte;
    logic       start_req;
    ts_kind_t   ts_kind;
  } entry_t;

  function automatic logic [2:0] popcount_high(input logic [7:0] b);
    popcount_high = 3'(b[4]) + 3'(b[5]) + 3'(b[6]) + 3'(b[7]);
  endfunction

endpackage

@@ design/scatr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_front
// Classifies an incoming byte: inverse-convention form and TS kind.
// ----------------------------------------------------------------------------
module scatr_front (
  input  scatr_pkg::in_item_t in_item,
  output scatr_pkg::entry_t   entry
);

  logic [7:0] rev;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[7 - i] = in_item.raw_byte[i];
    end
  end

  always_comb begin
    entry.raw_byte  = in_item.raw_byte;
    entry.inv_byte  = ~rev;
    entry.start_req = in_item.start_req;
    if (in_item.raw_byte == scatr_pkg::TS_DIRECT_BYTE) begin
      entry.ts_kind = scatr_pkg::TS_KIND_DIRECT;
    end else if (in_item.raw_byte == scatr_pkg::TS_INVERSE_BYTE) begin
      entry.ts_kind = scatr_pkg::TS_KIND_INVERSE;
    end else begin
      entry.ts_kind = scatr_pkg::TS_KIND_BAD;
    end
  end

endmodule

@@ design/scatr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_queue
// Two-entry queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module scatr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scatr_pkg::entry_t push_entry,
  output logic              full,
  output logic              not_empty,
  input  logic              pop,
  output scatr_pkg::entry_t pop_entry
);

  scatr_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule

@@ design/scatr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatr_back
// Parse state machine: walks T0, interface groups, historical bytes and TCK,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module scatr_back #(
  parameter int ATR_MAX = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  scatr_pkg::entry_t    q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scatr_pkg::out_item_t out_data
);

  localparam int LEN_W = $clog2(ATR_MAX + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_T0,
    PH_IFACE,
    PH_HIST,
    PH_TCK,
    PH_DONE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic                 inverse_r, inverse_nxt;
  logic [2:0]           group_left_r, group_left_nxt;
  logic                 group_td_r, group_td_nxt;
  logic [3:0]           hist_left_r, hist_left_nxt;
  logic [3:0]           protocol_r, protocol_nxt;
  logic [LEN_W-1:0]     length_r, length_nxt;
  logic                 out_valid_r, out_valid_nxt;
  scatr_pkg::out_item_t out_data_r, out_data_nxt;

  logic [7:0] dec;
  logic [2:0] gl_dec;
  logic       walk;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign dec       = inverse_r ? q_entry.inv_byte : q_entry.raw_byte;

  always_comb begin
    phase_nxt      = phase_r;
    inverse_nxt    = inverse_r;
    group_left_nxt = group_left_r;
    group_td_nxt   = group_td_r;
    hist_left_nxt  = hist_left_r;
    protocol_nxt   = protocol_r;
    length_nxt     = length_r;
    gl_dec         = (group_left_r != 3'd0) ? group_left_r - 3'd1 : group_left_r;
    walk           = 1'b0;
    out_data_nxt   = out_data_r;

    out_data_nxt.decoded_byte = dec;
    out_data_nxt.byte_index   = '0;
    out_data_nxt.byte_class   = scatr_pkg::CLS_IGNORED;
    out_data_nxt.done_res     = 1'b0;
    out_data_nxt.error        = scatr_pkg::ERR_NONE;

    if (q_entry.start_req) begin
      // a start request restarts the parse whatever the phase
      phase_nxt      = PH_IDLE;
      inverse_nxt    = 1'b0;
      group_left_nxt = '0;
      group_td_nxt   = 1'b0;
      hist_left_nxt  = '0;
      protocol_nxt   = '0;
      length_nxt     = '0;
      out_data_nxt.byte_class = scatr_pkg::CLS_TS;
      unique case (q_entry.ts_kind)
        scatr_pkg::TS_KIND_DIRECT: begin
          out_data_nxt.decoded_byte = scatr_pkg::TS_DIRECT_BYTE;
          phase_nxt  = PH_T0;
          length_nxt = LEN_W'(1);
        end
        scatr_pkg::TS_KIND_INVERSE: begin
          out_data_nxt.decoded_byte = scatr_pkg::TS_INVERSE_SHOW;
          inverse_nxt = 1'b1;
          phase_nxt   = PH_T0;
          length_nxt  = LEN_W'(1);
        end
        default: begin
          out_data_nxt.decoded_byte = q_entry.raw_byte;
          out_data_nxt.error        = scatr_pkg::ERR_BAD_TS;
        end
      endcase
    end else if (phase_r != PH_IDLE && phase_r != PH_DONE) begin
      out_data_nxt.byte_index = 6'(length_r);
      unique case (phase_r)
        PH_T0:    out_data_nxt.byte_class = scatr_pkg::CLS_T0;
        PH_IFACE: out_data_nxt.byte_class = scatr_pkg::CLS_IFACE;
        PH_HIST:  out_data_nxt.byte_class = scatr_pkg::CLS_HIST;
        default:  out_data_nxt.byte_class = scatr_pkg::CLS_TCK;
      endcase
      if (length_r >= LEN_W'(ATR_MAX)) begin
        out_data_nxt.error = scatr_pkg::ERR_OVFL;
        phase_nxt = PH_IDLE;
      end else begin
        length_nxt = length_r + LEN_W'(1);
        unique case (phase_r)
          PH_T0: begin
            hist_left_nxt  = dec[3:0];
            group_left_nxt = scatr_pkg::popcount_high(dec);
            group_td_nxt   = dec[7];
            walk = 1'b1;
          end
          PH_IFACE: begin
            // the last byte of a group with TD announced chains the next group
            if (gl_dec == 3'd0 && group_td_r) begin
              protocol_nxt   = dec[3:0];
              group_left_nxt = scatr_pkg::popcount_high(dec);
              group_td_nxt   = dec[7];
            end else begin
              group_left_nxt = gl_dec;
            end
            walk = 1'b1;
          end
          PH_HIST: begin
            if (hist_left_r != 4'd0) begin
              hist_left_nxt = hist_left_r - 4'd1;
            end
            walk = 1'b1;
          end
          default: phase_nxt = PH_DONE;
        endcase
        if (walk) begin
          if (group_left_nxt != 3'd0) begin
            phase_nxt = PH_IFACE;
          end else if (hist_left_nxt != 4'd0) begin
            phase_nxt = PH_HIST;
          end else if (protocol_nxt != 4'd0) begin
            phase_nxt = PH_TCK;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        out_data_nxt.done_res = (phase_nxt == PH_DONE);
      end
    end

    out_data_nxt.protocol = protocol_nxt;
    out_data_nxt.inverse  = inverse_nxt;

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      inverse_r    <= 1'b0;
      group_left_r <= '0;
      group_td_r   <= 1'b0;
      hist_left_r  <= '0;
      protocol_r   <= '0;
      length_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r      <= phase_nxt;
        inverse_r    <= inverse_nxt;
        group_left_r <= group_left_nxt;
        group_td_r   <= group_td_nxt;
        hist_left_r  <= hist_left_nxt;
        protocol_r   <= protocol_nxt;
        length_r     <= length_nxt;
      end
    end
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r) else $error("popped item not presented");
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> out_data_r.error == scatr_pkg::ERR_NONE)
    else $error("done with error");
  a_ignored_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_class == scatr_pkg::CLS_IGNORED
    |-> out_data_r.byte_index == 6'd0 && !out_data_r.done_res)
    else $error("ignored item carries index or done");
  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    group_left_r <= 3'd4) else $error("group count out of range");
`endif

endmodule

@@ design/smart_card_atr_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smart_card_atr_parser_unit
// Answer-to-reset byte parser: classifier, two-entry queue, parse engine.
// ----------------------------------------------------------------------------
//  channel  | ports                        | moves
//  input    | in_valid, in_stall, in_data  | one raw card byte, start flag
//  output   | out_valid, out_stall, out_data | decoded byte and parse status
//
//  one item per cycle while out_stall is low; an accepted item reaches
//  out_valid via the queue register, then the parse engine's output register
//  reset clears parse state and queue; no clearing pass
//  in_stall rises only when the two-entry queue is full
// ----------------------------------------------------------------------------
module smart_card_atr_parser_unit #(
  parameter int ATR_MAX = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scatr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scatr_pkg::out_item_t out_data
);

  scatr_pkg::entry_t front_entry;
  scatr_pkg::entry_t q_entry;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;

  assign in_stall = q_full;

  scatr_front u_front (
    .in_item (in_data),
    .entry   (front_entry)
  );

  scatr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_entry (front_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  scatr_back #(
    .ATR_MAX (ATR_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
